// ----- hdl/pscv_pkg.sv -----
`timescale 1ns / 1ps
package pscv_pkg;

	// Conversion codes carried by the operation field.
	typedef enum logic [3:0] {
		OP_S16_F        = 4'd0,
		OP_S32_F        = 4'd1,
		OP_F_S16        = 4'd2,
		OP_F_S32        = 4'd3,
		OP_S16_FSWAP    = 4'd4,
		OP_FSWAP_S16    = 4'd5,
		OP_S32_S16      = 4'd6,
		OP_S16_S32      = 4'd7,
		OP_S24_S16      = 4'd8,
		OP_S16_S24      = 4'd9,
		OP_S24_F        = 4'd10,
		OP_F_S24        = 4'd11,
		OP_S24IN32_S16  = 4'd12,
		OP_S16_S24IN32  = 4'd13,
		OP_S24IN32_F    = 4'd14,
		OP_F_S24IN32    = 4'd15
	} op_t;

	// Register index of the byte order control.
	localparam logic REG_INTEGER_BIG_ENDIAN = 1'b0;

	typedef struct packed {
		op_t         operation;
		logic [31:0] sample_in;
		logic        last_in;
	} item_t;

	typedef struct packed {
		logic [31:0] sample_out;
		logic        last_out;
	} result_t;

	function automatic logic [15:0] swap16(input logic [15:0] x);
		return {x[7:0], x[15:8]};
	endfunction

	function automatic logic [23:0] swap24(input logic [23:0] x);
		return {x[7:0], x[15:8], x[23:16]};
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

// ----- hdl/pscv_i2f.sv -----
`timescale 1ns / 1ps
module pscv_i2f import pscv_pkg::*; (
	input  logic        clk,
	input  logic [31:0] word,
	output logic [31:0] bits
);

	logic        sign_s2;
	logic [31:0] mag_s2;
	logic [4:0]  lz_s2;
	logic        zero_s2;
	logic [31:0] mag;
	logic [4:0]  lz;

	// Magnitude and leading zero count of the signed word.
	always_comb begin
		mag = word[31] ? (~word + 32'd1) : word;
		lz = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mag[i]) begin
				lz = 5'(31 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		sign_s2 <= word[31];
		mag_s2  <= mag;
		lz_s2   <= lz;
		zero_s2 <= (word == 32'd0);
	end

	logic [31:0] norm;
	logic        rnd;
	logic [24:0] mant;
	logic [7:0]  expo;
	logic [31:0] bits_c;

	// Normalize, round to nearest even and pack. The word is scaled by 2^-31.
	always_comb begin
		norm = mag_s2 << lz_s2;
		rnd  = norm[7] & ((|norm[6:0]) | norm[8]);
		mant = {1'b0, norm[31:8]} + {24'd0, rnd};
		expo = 8'd127 - {3'd0, lz_s2} + {7'd0, mant[24]};
		if (zero_s2) begin
			bits_c = 32'd0;
		end else begin
			bits_c = {sign_s2, expo, mant[24] ? 23'd0 : mant[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		bits <= bits_c;
	end

endmodule

// ----- hdl/pscv_f2i.sv -----
`timescale 1ns / 1ps
module pscv_f2i import pscv_pkg::*; (
	input  logic        clk,
	input  logic [31:0] fbits,
	input  logic        s16,
	output logic [31:0] value
);

	logic [7:0]  e;
	logic [7:0]  ee;
	logic [23:0] m_full;
	logic [8:0]  u;
	logic [62:0] w;

	// Align the mantissa so that bit 32 is the unit bit of the scaled value.
	always_comb begin
		e      = fbits[30:23];
		ee     = (e == 8'd0) ? 8'd1 : e;
		m_full = {(e != 8'd0), fbits[22:0]};
		u      = (s16 ? 9'd142 : 9'd126) - {1'b0, ee};
		if (ee >= 8'd127 || u[8] || u[7:6] != 2'b00) begin
			w = 63'd0;
		end else begin
			w = {m_full, 39'd0} >> u[5:0];
		end
	end

	logic [62:0] w_s2;
	logic        sign_s2;
	logic        big_s2;
	logic        nan_s2;
	logic        s16_s2;

	always_ff @(posedge clk) begin
		w_s2    <= w;
		sign_s2 <= fbits[31];
		big_s2  <= (ee >= 8'd127);
		nan_s2  <= (e == 8'hFF) && (fbits[22:0] != 23'd0);
		s16_s2  <= s16;
	end

	logic [31:0] mag;
	logic [31:0] lim;
	logic        over;
	logic [31:0] value_c;

	// Round to nearest even, apply the sign and saturate; a NaN gives zero.
	always_comb begin
		mag  = {1'b0, w_s2[62:32]} +
			{31'd0, w_s2[31] & ((|w_s2[30:0]) | w_s2[32])};
		lim  = s16_s2 ? 32'h0000_8000 : 32'h8000_0000;
		over = big_s2 || (mag >= lim);
		if (nan_s2) begin
			value_c = 32'd0;
		end else if (!sign_s2) begin
			value_c = over ? (lim - 32'd1) : mag;
		end else begin
			value_c = over ? (~lim + 32'd1) : (~mag + 32'd1);
		end
	end

	always_ff @(posedge clk) begin
		value <= value_c;
	end

endmodule

// ----- hdl/pcm_sample_format_converter.sv -----
`timescale 1ns / 1ps
// PCM sample format converter.
// One sample transfer per cycle on the command side: an item is taken at
// a rising edge with start high and busy low. busy is always low, so a new
// sample may be presented in every cycle.
// The result appears on result for exactly one cycle with done high,
// after the item has passed the input stage, the two arithmetic stages
// in the integer-to-float and float-to-integer units and the output stage.
// Throughput is one sample per cycle; four samples can be in flight.
// The receiver cannot stall; it must take each result while done is high.
// The APB port holds one register at address 0: bit 0 selects byte-reversed
// integer words. Write it only while no samples are in flight.
// Reset clears the byte order bit and all stage valid bits; samples in
// flight are dropped.
module pcm_sample_format_converter import pscv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic be_q;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			be_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == REG_INTEGER_BIG_ENDIAN) begin
			be_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == REG_INTEGER_BIG_ENDIAN) ? {31'd0, be_q} : 32'd0;

	assign busy = 1'b0;

	// Input stage: undo or apply byte order and prepare each path's operand.
	logic [31:0] x;
	logic [31:0] xs32;
	logic [15:0] xs16;
	logic [23:0] xs24;
	logic [31:0] d;
	logic [31:0] w32;
	logic [23:0] w24;

	always_comb begin
		x    = item.sample_in;
		xs32 = be_q ? swap32(x) : x;
		xs16 = be_q ? swap16(x[15:0]) : x[15:0];
		xs24 = be_q ? swap24(x[23:0]) : x[23:0];
		w32  = 32'd0;
		w24  = 24'd0;
		case (item.operation)
			OP_S16_F, OP_S16_FSWAP: d = {xs16, 16'd0};
			OP_S32_F:               d = xs32;
			OP_S24_F:               d = {xs24, 8'd0};
			OP_S24IN32_F:           d = {xs32[23:0], 8'd0};
			OP_FSWAP_S16:           d = swap32(x);
			OP_F_S16, OP_F_S32, OP_F_S24, OP_F_S24IN32: d = x;
			OP_S32_S16:             d = {16'd0, xs32[31:16]};
			OP_S24_S16:             d = {16'd0, xs24[23:8]};
			OP_S24IN32_S16:         d = {16'd0, xs32[23:8]};
			OP_S16_S32: begin
				w32 = {x[15:0], 16'd0};
				d   = be_q ? swap32(w32) : w32;
			end
			OP_S16_S24: begin
				w24 = {x[15:0], 8'd0};
				d   = {8'd0, be_q ? swap24(w24) : w24};
			end
			OP_S16_S24IN32: begin
				w32 = {8'd0, x[15:0], 8'd0};
				d   = be_q ? swap32(w32) : w32;
			end
			default: d = x;
		endcase
	end

	logic        valid_s1, valid_s2, valid_s3;
	op_t         op_s1, op_s2, op_s3;
	logic        be_s1, be_s2, be_s3;
	logic        last_s1, last_s2, last_s3;
	logic        s16_s1;
	logic [31:0] data_s1, data_s2, data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= item.operation;
		be_s1   <= be_q;
		last_s1 <= item.last_in;
		s16_s1  <= (item.operation == OP_F_S16) || (item.operation == OP_FSWAP_S16);
		data_s1 <= d;
		op_s2   <= op_s1;
		be_s2   <= be_s1;
		last_s2 <= last_s1;
		data_s2 <= data_s1;
		op_s3   <= op_s2;
		be_s3   <= be_s2;
		last_s3 <= last_s2;
		data_s3 <= data_s2;
	end

	// Arithmetic units, two stages each.
	logic [31:0] fl_s3;
	logic [31:0] int_s3;

	pscv_i2f u_i2f (
		.clk  (clk),
		.word (data_s1),
		.bits (fl_s3)
	);

	pscv_f2i u_f2i (
		.clk   (clk),
		.fbits (data_s1),
		.s16   (s16_s1),
		.value (int_s3)
	);

	// Output stage: select the path and apply the output byte order.
	logic [31:0] r;
	logic [31:0] o32;
	logic [23:0] o24;

	always_comb begin
		o32 = 32'd0;
		o24 = 24'd0;
		case (op_s3)
			OP_S16_F, OP_S32_F, OP_S24_F, OP_S24IN32_F: r = fl_s3;
			OP_S16_FSWAP: r = swap32(fl_s3);
			OP_F_S16, OP_FSWAP_S16:
				r = {16'd0, be_s3 ? swap16(int_s3[15:0]) : int_s3[15:0]};
			OP_F_S32: r = be_s3 ? swap32(int_s3) : int_s3;
			OP_F_S24: begin
				o24 = int_s3[31:8];
				r   = {8'd0, be_s3 ? swap24(o24) : o24};
			end
			OP_F_S24IN32: begin
				o32 = {8'd0, int_s3[31:8]};
				r   = be_s3 ? swap32(o32) : o32;
			end
			default: r = data_s3;
		endcase
	end

	logic        done_s4;
	logic [31:0] sample_s4;
	logic        last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		sample_s4 <= r;
		last_s4   <= last_s3;
	end

	assign done              = done_s4;
	assign result.sample_out = sample_s4;
	assign result.last_out   = last_s4;

	// Every accepted item comes out with a result strobe.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("result strobe missing four cycles after transfer");

	// No result without an earlier transfer.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result strobe without a transfer");

	// A NaN into the 32-bit integer path gives zero.
	a_nan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.operation == OP_F_S32 &&
		item.sample_in[30:23] == 8'hFF && item.sample_in[22:0] != 23'd0
		|-> ##4 (result.sample_out == 32'd0))
		else $error("NaN did not convert to zero");

endmodule

// ----- dv/pcm_sample_format_converter_test.sv -----
`timescale 1ns / 1ps
module pcm_sample_format_converter_test;
	import pscv_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_SHOWN = 10;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pcm_sample_format_converter dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	// Testbench copy of the byte order register.
	logic    swap_ints;
	result_t pending_samples[$];
	int      mismatches;
	int      samples_sent;
	int      samples_checked;
	int      idle_cycles;
	int      sender_idle_pct;

	// Directed stimulus: typed rows carry a result readable at a glance.
	typedef struct {
		op_t         op;
		logic [31:0] sample;
		logic        last;
		logic        typed;
		logic [31:0] want;
	} vector_t;

	vector_t vectors[] = '{
		'{OP_S16_F,       32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
		'{OP_S16_F,       32'h0000_8000, 1'b1, 1'b1, 32'hBF80_0000},
		'{OP_S16_F,       32'hFFFF_7FFF, 1'b0, 1'b0, 32'h0},
		'{OP_S32_F,       32'h8000_0000, 1'b0, 1'b1, 32'hBF80_0000},
		'{OP_S32_F,       32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
		'{OP_F_S16,       32'h7FC0_0000, 1'b0, 1'b1, 32'h0000_0000},
		'{OP_F_S16,       32'hFF80_0000, 1'b0, 1'b1, 32'h0000_8000},
		'{OP_F_S16,       32'h3F80_0000, 1'b1, 1'b1, 32'h0000_7FFF},
		'{OP_F_S32,       32'h3F80_0000, 1'b0, 1'b1, 32'h7FFF_FFFF},
		'{OP_F_S32,       32'hBF80_0000, 1'b0, 1'b1, 32'h8000_0000},
		'{OP_F_S32,       32'hFFC0_0001, 1'b1, 1'b1, 32'h0000_0000},
		'{OP_S16_FSWAP,   32'h0000_8000, 1'b0, 1'b1, 32'h0000_80BF},
		'{OP_FSWAP_S16,   32'h0000_803F, 1'b0, 1'b1, 32'h0000_7FFF},
		'{OP_S32_S16,     32'h8765_4321, 1'b1, 1'b1, 32'h0000_8765},
		'{OP_S16_S32,     32'hFFFF_8001, 1'b0, 1'b1, 32'h8001_0000},
		'{OP_S24_S16,     32'hFF80_0000, 1'b0, 1'b1, 32'h0000_8000},
		'{OP_S16_S24,     32'h1234_7FFF, 1'b0, 1'b1, 32'h007F_FF00},
		'{OP_S24_F,       32'h0080_0000, 1'b1, 1'b1, 32'hBF80_0000},
		'{OP_F_S24,       32'h3F80_0000, 1'b0, 1'b1, 32'h007F_FFFF},
		'{OP_S24IN32_S16, 32'hAB7F_FFFF, 1'b0, 1'b1, 32'h0000_7FFF},
		'{OP_S16_S24IN32, 32'h0000_FFFF, 1'b0, 1'b1, 32'h00FF_FF00},
		'{OP_S24IN32_F,   32'hFF7F_FFFF, 1'b1, 1'b0, 32'h0},
		'{OP_F_S24IN32,   32'h7F80_0000, 1'b0, 1'b1, 32'h007F_FFFF},
		'{OP_F_S24IN32,   32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000},
		'{OP_F_S16,       32'h3780_0000, 1'b0, 1'b1, 32'h0000_0000}
	};

	// Clock.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Byte reversal helpers for 16, 24 and 32 bit integer words.
	function automatic logic [31:0] rev16(input logic [31:0] x);
		return {16'h0, x[7:0], x[15:8]};
	endfunction

	function automatic logic [31:0] rev24(input logic [31:0] x);
		return {8'h0, x[7:0], x[15:8], x[23:16]};
	endfunction

	function automatic logic [31:0] rev32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	// Signed integer divided by 2^scale, rounded to the nearest binary32.
	function automatic logic [31:0] int_to_f32(input longint v, input int scale);
		logic        sgn;
		longint      m;
		longint      rem;
		longint      half;
		longint      q;
		int          p;
		int          rs;
		logic [7:0]  ex;
		if (v == 0) begin
			return 32'h0;
		end
		sgn = v < 0;
		m = sgn ? -v : v;
		p = 0;
		for (int i = 0; i < 40; i++) begin
			if (m[i]) p = i;
		end
		if (p > 23) begin
			rs = p - 23;
			q = m >>> rs;
			rem = m & ((64'd1 << rs) - 1);
			half = 64'd1 << (rs - 1);
			if (rem > half || (rem == half && q[0])) q++;
			if (q[24]) begin
				q = q >>> 1;
				p++;
			end
		end else begin
			q = m << (23 - p);
		end
		ex = 8'(p - scale + 127);
		return {sgn, ex, q[22:0]};
	endfunction

	// binary32 times 2^k, rounded half to even; anything of magnitude two
	// or more comes back as a huge value for the caller to clamp.
	function automatic longint f32_scaled(input logic [31:0] b, input int k);
		int     e;
		int     sh;
		int     rs;
		longint mant;
		longint q;
		longint rem;
		longint half;
		e = int'(b[30:23]);
		mant = longint'(b[22:0]);
		if (e != 0) mant = mant | 64'h80_0000;
		if (e >= 128) begin
			q = 64'd1 << 40;
		end else begin
			sh = (e == 0 ? 1 : e) - 150 + k;
			if (sh >= 0) begin
				q = mant << sh;
			end else begin
				rs = -sh;
				if (rs > 30) begin
					q = 0;
				end else begin
					q = mant >>> rs;
					rem = mant & ((64'd1 << rs) - 1);
					half = 64'd1 << (rs - 1);
					if (rem > half || (rem == half && q[0])) q++;
				end
			end
		end
		return b[31] ? -q : q;
	endfunction

	function automatic logic is_nan(input logic [31:0] b);
		return b[30:23] == 8'hFF && b[22:0] != 0;
	endfunction

	function automatic logic [31:0] f32_to_s16(input logic [31:0] b);
		longint t;
		if (is_nan(b)) return 32'h0;
		t = f32_scaled(b, 15);
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return {16'h0, t[15:0]};
	endfunction

	function automatic logic [31:0] f32_to_s32(input logic [31:0] b);
		longint t;
		if (is_nan(b)) return 32'h0;
		t = f32_scaled(b, 31);
		if (t > 64'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
		if (t < -64'sh8000_0000) t = -64'sh8000_0000;
		return t[31:0];
	endfunction

	function automatic logic [31:0] s16_to_f32(input logic [31:0] x);
		return int_to_f32(longint'($signed(x[15:0])), 15);
	endfunction

	function automatic logic [31:0] s32_to_f32(input logic [31:0] x);
		return int_to_f32(longint'($signed(x)), 31);
	endfunction

	// Expected converted sample for one item under the current byte order.
	function automatic result_t convert_sample(input item_t it, input logic be);
		logic [31:0] x;
		logic [31:0] r;
		result_t     res;
		x = it.sample_in;
		case (it.operation)
			OP_S16_F:       r = s16_to_f32(be ? rev16(x) : x);
			OP_S32_F:       r = s32_to_f32(be ? rev32(x) : x);
			OP_F_S16: begin
				r = f32_to_s16(x);
				if (be) r = rev16(r);
			end
			OP_F_S32: begin
				r = f32_to_s32(x);
				if (be) r = rev32(r);
			end
			OP_S16_FSWAP:   r = rev32(s16_to_f32(be ? rev16(x) : x));
			OP_FSWAP_S16: begin
				r = f32_to_s16(rev32(x));
				if (be) r = rev16(r);
			end
			OP_S32_S16:     r = ((be ? rev32(x) : x) >> 16) & 32'hFFFF;
			OP_S16_S32: begin
				r = {x[15:0], 16'h0};
				if (be) r = rev32(r);
			end
			OP_S24_S16:     r = ((be ? rev24(x) : x) >> 8) & 32'hFFFF;
			OP_S16_S24: begin
				r = {8'h0, x[15:0], 8'h0};
				if (be) r = rev24(r);
			end
			OP_S24_F:       r = s32_to_f32(((be ? rev24(x) : x) & 32'hFF_FFFF) << 8);
			OP_F_S24: begin
				r = f32_to_s32(x) >> 8;
				if (be) r = rev24(r);
			end
			OP_S24IN32_S16: r = ((be ? rev32(x) : x) >> 8) & 32'hFFFF;
			OP_S16_S24IN32: begin
				r = {8'h0, x[15:0], 8'h0};
				if (be) r = rev32(r);
			end
			OP_S24IN32_F:   r = s32_to_f32(((be ? rev32(x) : x) & 32'hFF_FFFF) << 8);
			default: begin
				r = f32_to_s32(x) >> 8;
				if (be) r = rev32(r);
			end
		endcase
		res.sample_out = r;
		res.last_out = it.last_in;
		return res;
	endfunction

	// Present one sample, wait for its transfer, then leave a gap if asked.
	// Each following cycle is idle with the chosen percentage.
	task automatic send_sample(input item_t it, input logic typed, input logic [31:0] want);
		logic    taken;
		result_t exp_res;
		item <= it;
		start <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		exp_res = convert_sample(it, swap_ints);
		if (typed) exp_res.sample_out = want;
		pending_samples.push_back(exp_res);
		samples_sent++;
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
		end
	endtask

	// Let the pipeline drain, then write the byte order register.
	task automatic set_byte_order(input logic be);
		start <= 1'b0;
		wait (pending_samples.size() == 0);
		repeat (6) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(4 * REG_INTEGER_BIG_ENDIAN);
		pwdata <= {31'h0, be};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		swap_ints = be;
	endtask

	// Random sample word, biased toward floats near full scale and ties.
	function automatic logic [31:0] pick_sample();
		logic [31:0] w;
		w = $urandom();
		case ($urandom_range(9))
			0: w = $urandom_range(1) ? 32'h3F80_0000 : 32'hBF80_0000;
			1: w = {w[31], 8'hFF, $urandom_range(1) ? 23'h0 : w[22:0]};
			2: w = {w[31], 8'(126 + $urandom_range(1)), w[22:0]};
			3: w = {w[31], 8'($urandom_range(100, 127)), w[22:8], 8'h0};
			4: w = {w[31], 8'($urandom_range(103, 113)), w[22:0] & 23'h7F_FF00};
			5: w = {w[31], 8'($urandom_range(0, 2)), w[22:0]};
			6: w = {w[31:24], $urandom_range(1) ? 24'h80_0000 : 24'h7F_FFFF};
			7: w = {w[31:16], $urandom_range(1) ? 16'h8000 : 16'h7FFF};
			default: ;
		endcase
		return w;
	endfunction

	task automatic random_samples(input int count);
		item_t it;
		for (int i = 0; i < count; i++) begin
			it.operation = op_t'($urandom_range(15));
			it.sample_in = pick_sample();
			it.last_in = $urandom_range(7) == 0;
			send_sample(it, 1'b0, 32'h0);
		end
	endtask

	// Compare each result transfer with the oldest expected sample.
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && done) begin
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result %h last %b", result.sample_out,
						result.last_out);
			end else begin
				exp_res = pending_samples.pop_front();
				samples_checked++;
				if (result.sample_out !== exp_res.sample_out ||
						result.last_out !== exp_res.last_out) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("sample mismatch: expected %h/%b, got %h/%b",
							exp_res.sample_out, exp_res.last_out,
							result.sample_out, result.last_out);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d samples outstanding",
					pending_samples.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		item_t it;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		swap_ints = 1'b0;
		mismatches = 0;
		samples_sent = 0;
		samples_checked = 0;
		idle_cycles = 0;
		sender_idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows, first in reset byte order, then byte reversed.
		foreach (vectors[i]) begin
			it.operation = vectors[i].op;
			it.sample_in = vectors[i].sample;
			it.last_in = vectors[i].last;
			send_sample(it, vectors[i].typed, vectors[i].want);
		end
		set_byte_order(1'b1);
		foreach (vectors[i]) begin
			it.operation = vectors[i].op;
			it.sample_in = vectors[i].sample;
			it.last_in = vectors[i].last;
			send_sample(it, 1'b0, 32'h0);
		end

		// Random phases across byte orders and sender idle rates.
		sender_idle_pct = 26;
		random_samples(125);
		set_byte_order(1'b0);
		random_samples(125);
		sender_idle_pct = 52;
		set_byte_order(1'b1);
		random_samples(125);
		set_byte_order(1'b0);
		random_samples(125);
		sender_idle_pct = 0;
		random_samples(125);
		set_byte_order(1'b1);
		random_samples(125);

		start <= 1'b0;
		wait (pending_samples.size() == 0);
		repeat (8) @(posedge clk);
		$display("Sent %0d samples over all 16 conversions in both byte orders,",
			samples_sent);
		$display("with sender gaps of 0, 26 and 52 percent; %0d results checked.",
			samples_checked);
		if (mismatches == 0 && pending_samples.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/pscv_pkg.sv
hdl/pscv_i2f.sv
hdl/pscv_f2i.sv
hdl/pcm_sample_format_converter.sv
dv/pcm_sample_format_converter_test.sv
